// ===== hw/rtl/rtc_pkg.sv =====
package rtc_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   typedef enum logic [1:0] {
      REQ_TICK        = 2'd0,
      REQ_SET_TIME    = 2'd1,
      REQ_WRITE_FLAGS = 2'd2
   } req_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CONTROL      = 3'd0,
      CSR_ALARM_HOUR   = 3'd1,
      CSR_ALARM_MINUTE = 3'd2,
      CSR_ALARM_SECOND = 3'd3,
      CSR_NMI_ENABLE   = 3'd4
   } csr_index_type;

   localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;
   localparam logic [5:0] MINUTES_PER_HOUR   = 6'd60;
   localparam logic [4:0] HOURS_PER_DAY      = 5'd24;
   localparam logic [6:0] NMI_PHASE          = 7'd64;
   localparam int         ALARM_ARM_BIT      = 7;
   localparam int         CTRL_IRQ_EN_BIT    = 0;
   localparam int         CTRL_ALARM_EN_BIT  = 1;
   localparam int         FLAG_TICK_BIT      = 0;
   localparam int         FLAG_ALARM_BIT     = 1;

   typedef struct packed {
      logic [1:0] control;
      logic [7:0] alarm_hour;
      logic [7:0] alarm_minute;
      logic [7:0] alarm_second;
      logic       nmi_enable;
   } rtc_cfg_type;

   typedef struct packed {
      logic [7:0] phase;
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [7:0] day;
      logic [1:0] flags;
   } rtc_state_type;

   typedef struct packed {
      logic [7:0] sub_second;
      logic       irq;
      logic       alarm;
      logic       nmi;
   } rtc_event_type;

endpackage

// ===== hw/rtl/rtc_if.sv =====
interface rtc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [4:0] set_hour;
   logic [5:0] set_minute;
   logic [5:0] set_second;
   logic [7:0] set_day;
   logic [1:0] flag_value;

   modport source (output valid, req_type, set_hour, set_minute, set_second, set_day,
                   flag_value, input ready);
   modport sink (input valid, req_type, set_hour, set_minute, set_second, set_day,
                 flag_value, output ready);
endinterface

interface rtc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] sub_second;
   logic [5:0] seconds_now;
   logic [5:0] minutes_now;
   logic [4:0] hours_now;
   logic [7:0] day_now;
   logic       irq_out;
   logic       alarm_hit;
   logic       nmi_out;
   logic [1:0] flags_now;

   modport source (output valid, sub_second, seconds_now, minutes_now, hours_now, day_now,
                   irq_out, alarm_hit, nmi_out, flags_now, input ready);
   modport sink (input valid, sub_second, seconds_now, minutes_now, hours_now, day_now,
                 irq_out, alarm_hit, nmi_out, flags_now, output ready);
endinterface

interface rtc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [rtc_pkg::CSR_INDEX_W-1:0]  index;
   logic [rtc_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/rtc_csr.sv =====
module rtc_csr (
   input  logic                clock,
   input  logic                reset,
   rtc_csr_if.sink             csr_bus,
   output rtc_pkg::rtc_cfg_type cfg
);
   import rtc_pkg::*;

   rtc_cfg_type cfg_ff;
   rtc_cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg           = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_CONTROL:      cfg_in.control      = csr_bus.data[1:0];
            CSR_ALARM_HOUR:   cfg_in.alarm_hour   = csr_bus.data;
            CSR_ALARM_MINUTE: cfg_in.alarm_minute = csr_bus.data;
            CSR_ALARM_SECOND: cfg_in.alarm_second = csr_bus.data;
            CSR_NMI_ENABLE:   cfg_in.nmi_enable   = csr_bus.data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hw/rtl/rtc_step.sv =====
module rtc_step (
   input  rtc_pkg::rtc_state_type state,
   input  rtc_pkg::rtc_cfg_type   cfg,
   input  logic [1:0]             req_type,
   input  logic [4:0]             set_hour,
   input  logic [5:0]             set_minute,
   input  logic [5:0]             set_second,
   input  logic [7:0]             set_day,
   input  logic [1:0]             flag_value,
   output rtc_pkg::rtc_state_type state_next,
   output rtc_pkg::rtc_event_type events
);
   import rtc_pkg::*;

   rtc_state_type tick_state;
   logic          at_zero;
   logic          alarm_fire;
   logic          hour_ok;
   logic          minute_ok;
   logic          second_ok;
   logic          armed;

   // time advance and alarm compare for a tick
   always_comb begin
      tick_state = state;
      at_zero    = (state.phase == 8'd0);
      if (at_zero) begin
         tick_state.second = state.second + 6'd1;
         if (tick_state.second == SECONDS_PER_MINUTE) begin
            tick_state.second = '0;
            tick_state.minute = state.minute + 6'd1;
            if (tick_state.minute == MINUTES_PER_HOUR) begin
               tick_state.minute = '0;
               tick_state.hour   = state.hour + 5'd1;
               if (tick_state.hour == HOURS_PER_DAY) begin
                  tick_state.hour = '0;
                  tick_state.day  = state.day + 8'd1;
               end
            end
         end
      end
      hour_ok    = !cfg.alarm_hour[ALARM_ARM_BIT]
                   || (cfg.alarm_hour[4:0] == tick_state.hour);
      minute_ok  = !cfg.alarm_minute[ALARM_ARM_BIT]
                   || (cfg.alarm_minute[5:0] == tick_state.minute);
      second_ok  = !cfg.alarm_second[ALARM_ARM_BIT]
                   || (cfg.alarm_second[5:0] == tick_state.second);
      armed      = cfg.alarm_hour[ALARM_ARM_BIT] || cfg.alarm_minute[ALARM_ARM_BIT]
                   || cfg.alarm_second[ALARM_ARM_BIT];
      alarm_fire = at_zero && cfg.control[CTRL_ALARM_EN_BIT] && state.flags[FLAG_ALARM_BIT]
                   && armed && hour_ok && minute_ok && second_ok;
      if (alarm_fire) begin
         tick_state.flags[FLAG_ALARM_BIT] = 1'b0;
      end
      tick_state.phase = state.phase + 8'd1;
   end

   always_comb begin
      state_next = state;
      events     = '0;
      unique case (req_kind_type'(req_type))
         REQ_TICK: begin
            state_next        = tick_state;
            events.sub_second = state.phase;
            events.alarm      = alarm_fire;
            events.irq        = (state.phase[6:0] == 7'd0) && !alarm_fire
                                && cfg.control[CTRL_IRQ_EN_BIT] && state.flags[FLAG_TICK_BIT];
            events.nmi        = (state.phase[6:0] == NMI_PHASE) && cfg.nmi_enable;
         end
         REQ_SET_TIME: begin
            state_next.hour   = set_hour;
            state_next.minute = set_minute;
            state_next.second = set_second;
            state_next.day    = set_day;
         end
         REQ_WRITE_FLAGS: begin
            state_next.flags = flag_value;
         end
         default: begin
            state_next = state;
         end
      endcase
   end

endmodule

// ===== hw/rtl/rtc_time_alarm_interrupts.sv =====
// an accepted request's response is registered and shows on the output register in the cycle after it is taken
// throughput: one request per cycle, limited only by the single output register
// the next request sees the counters left by the previous one through the state registers
// reset: synchronous, active high; clears time, flags, phase, control registers and
// the response valid
module rtc_time_alarm_interrupts (
   input  logic       clock,
   input  logic       reset,
   rtc_req_if.sink    req_bus,
   rtc_rsp_if.source  rsp_bus,
   rtc_csr_if.sink    csr_bus
);
   import rtc_pkg::*;

   rtc_cfg_type   cfg;
   rtc_state_type state_ff;
   rtc_state_type state_next;
   rtc_state_type state_in;
   rtc_event_type events;
   rtc_event_type event_ff;
   rtc_state_type view_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          req_take;

   rtc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   rtc_step u_step (
      .state      (state_ff),
      .cfg        (cfg),
      .req_type   (req_bus.req_type),
      .set_hour   (req_bus.set_hour),
      .set_minute (req_bus.set_minute),
      .set_second (req_bus.set_second),
      .set_day    (req_bus.set_day),
      .flag_value (req_bus.flag_value),
      .state_next (state_next),
      .events     (events)
   );

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      state_in     = req_take ? state_next : state_ff;
      rsp_valid_in = req_take || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         view_ff  <= state_next;
         event_ff <= events;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.sub_second  = event_ff.sub_second;
   assign rsp_bus.seconds_now = view_ff.second;
   assign rsp_bus.minutes_now = view_ff.minute;
   assign rsp_bus.hours_now   = view_ff.hour;
   assign rsp_bus.day_now     = view_ff.day;
   assign rsp_bus.irq_out     = event_ff.irq;
   assign rsp_bus.alarm_hit   = event_ff.alarm;
   assign rsp_bus.nmi_out     = event_ff.nmi;
   assign rsp_bus.flags_now   = view_ff.flags;

   a_alarm_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && event_ff.alarm |-> (event_ff.sub_second == 8'd0) && !event_ff.irq)
      else $error("alarm reported away from phase zero or together with irq");

   a_irq_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && event_ff.irq |-> (event_ff.sub_second[6:0] == 7'd0))
      else $error("irq reported away from a half-second phase");

   a_nmi_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && event_ff.nmi |-> (event_ff.sub_second[6:0] == NMI_PHASE))
      else $error("nmi reported away from its phase");

   a_tick_phase: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_bus.req_type == REQ_TICK) |=> state_ff.phase == $past(state_ff.phase) + 8'd1)
      else $error("tick transaction did not advance the phase");

   a_alarm_clears: assert property (@(posedge clock) disable iff (reset)
      req_take && events.alarm |=> !state_ff.flags[FLAG_ALARM_BIT])
      else $error("alarm flag still set after alarm");

endmodule
